[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the matrix multiply block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

[hw/rtl/dmm_pkg.sv]
// Shared types and constants of the dense matrix multiply block.
// Depends on nothing.
package dmm_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int SIZE_W = 5;
    localparam int FIELD_IDX_W = 4;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Word handed from one cell to the next.
    typedef struct packed {
        logic                     valid;
        logic signed [ELEM_W-1:0] a;
    } cell_ctl_t;

endpackage

[hw/rtl/dmm_cell.sv]
// One column cell: holds a column of B, multiplies the passing A element
// and accumulates one element of the result row. Depends on dmm_pkg.
module dmm_cell #(
    parameter int MAX_DIM = 16,
    parameter int IDX_W   = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              wr_en,
    input  logic [IDX_W-1:0]                  wr_row,
    input  logic signed [dmm_pkg::ELEM_W-1:0] wr_data,
    input  dmm_pkg::cell_ctl_t                in_ctl,
    input  logic [IDX_W-1:0]                  in_k,
    output dmm_pkg::cell_ctl_t                out_ctl,
    output logic [IDX_W-1:0]                  out_k,
    output logic signed [dmm_pkg::ACC_W-1:0]  acc
);

    logic signed [dmm_pkg::ELEM_W-1:0] bmem [MAX_DIM];
    logic signed [dmm_pkg::ELEM_W-1:0] b_rd_reg;
    logic                              v_s1_reg;
    logic signed [dmm_pkg::ELEM_W-1:0] a_s1_reg;
    logic [IDX_W-1:0]                  k_s1_reg;
    logic signed [dmm_pkg::PROD_W-1:0] prod_reg;
    logic                              v_s2_reg;
    logic signed [dmm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [dmm_pkg::ACC_W-1:0]  acc_next;

    // B column storage with registered read at the passing k
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bmem[wr_row] <= wr_data;
        end
        b_rd_reg <= bmem[in_k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg <= 1'b0;
            v_s2_reg <= 1'b0;
        end
        else
        begin
            v_s1_reg <= in_ctl.valid;
            v_s2_reg <= v_s1_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (v_s2_reg)
        begin
            acc_next = acc_reg + dmm_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        a_s1_reg <= in_ctl.a;
        k_s1_reg <= in_k;
        prod_reg <= a_s1_reg * b_rd_reg;
        acc_reg  <= acc_next;
    end

    assign out_ctl.valid = v_s1_reg;
    assign out_ctl.a     = a_s1_reg;
    assign out_k         = k_s1_reg;
    assign acc           = acc_reg;

endmodule

[hw/rtl/dense_matrix_multiply.sv]
// Dense square matrix multiply C = A x B in signed Q8.8 with exact Q24.16
// sums. A load word (tuser 0 or 1) writes one element of A or B.
// A compute word (tuser 2) for row i streams row i of A from the single A
// memory port down a chain of MAX_DIM column cells, waits for the chain and
// the multiply pipeline to drain, then emits the n elements of row i of C, one
// word per cycle when the sink is ready, the last with tlast. Words are not
// taken while a row is in flight.
// Depends on dmm_pkg, dmm_cell and assert_macros.svh.
`include "assert_macros.svh"

module dense_matrix_multiply #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,  // size_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // row_index[3:0], col_index[7:4], element_value[23:8]
    input  logic [1:0]  s_tuser,      // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // out_col[3:0], product_value[43:4], zero[47:44]
    output logic        m_tlast       // last_of_row
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int STEP_W = $clog2(2 * MAX_DIM + 6);
    localparam int AMEM_D = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (AMEM_D > 1) ? $clog2(AMEM_D) : 1;
    localparam int DRAIN  = MAX_DIM + 4;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

    state_t                            state_reg;
    logic [dmm_pkg::SIZE_W-1:0]        size_reg;
    logic [CNT_W-1:0]                  n_eff;
    logic [IDX_W-1:0]                  row_reg;
    logic [STEP_W-1:0]                 step_reg;
    logic [IDX_W-1:0]                  col_reg;
    logic                              m_tvalid_reg;
    logic [47:0]                       m_tdata_reg;
    logic                              m_tlast_reg;

    logic [1:0]                        cmd;
    logic [3:0]                        in_row;
    logic [3:0]                        in_col;
    logic signed [dmm_pkg::ELEM_W-1:0] in_val;
    logic                              accept;
    logic                              load_ok;
    logic                              a_wr;
    logic                              b_wr;
    logic                              start;
    logic [ADDR_W-1:0]                 a_wr_addr;
    logic [ADDR_W-1:0]                 a_rd_addr;
    logic                              issue;
    logic                              emit_now;
    logic                              last_col;

    logic signed [dmm_pkg::ELEM_W-1:0] amem [AMEM_D];
    logic signed [dmm_pkg::ELEM_W-1:0] a_rd_reg;
    logic                              a_v_reg;
    logic [IDX_W-1:0]                  a_k_reg;

    dmm_pkg::cell_ctl_t                link_ctl [MAX_DIM+1];
    logic [IDX_W-1:0]                  link_k   [MAX_DIM+1];
    logic signed [dmm_pkg::ACC_W-1:0]  acc      [MAX_DIM];

    // Unpack the input word
    assign cmd    = s_tuser;
    assign in_row = s_tdata[3:0];
    assign in_col = s_tdata[7:4];
    assign in_val = s_tdata[23:8];

    // Clamp the size register into 1..MAX_DIM
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(size_reg) > MAX_DIM)
        begin
            n_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            n_eff = CNT_W'(size_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_ok  = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign a_wr     = accept && (cmd == dmm_pkg::CMD_LOAD_A) && load_ok;
    assign b_wr     = accept && (cmd == dmm_pkg::CMD_LOAD_B) && load_ok;
    assign start    = accept && (cmd == dmm_pkg::CMD_COMPUTE) && (32'(in_row) < 32'(n_eff));
    assign a_wr_addr = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
    assign a_rd_addr = ADDR_W'(32'(row_reg) * MAX_DIM + 32'(step_reg));
    assign issue     = (state_reg == ST_RUN) && (32'(step_reg) < 32'(n_eff));
    assign emit_now  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign last_col  = (32'(col_reg) + 1 == 32'(n_eff));

    // A memory: one write port for loads, one registered read port for streaming
    always_ff @(posedge clk)
    begin
        if (a_wr)
        begin
            amem[a_wr_addr] <= in_val;
        end
        a_rd_reg <= amem[a_rd_addr];
        a_k_reg  <= IDX_W'(step_reg);
    end

    // Control, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            size_reg     <= dmm_pkg::SIZE_RESET;
            row_reg      <= '0;
            step_reg     <= '0;
            col_reg      <= '0;
            a_v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            a_v_reg <= issue;
            // Drop the output word once taken, unless a new one replaces it
            if (m_tready && !emit_now)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        row_reg   <= IDX_W'(in_row);
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    // Stream row of A, then wait for the chain to drain
                    if (32'(step_reg) == 32'(n_eff) + DRAIN)
                    begin
                        col_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_now)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, acc[col_reg], 4'(col_reg)};
                        m_tlast_reg  <= last_col;
                        if (last_col)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Chain of column cells: the A element walks one cell per cycle
    assign link_ctl[0].valid = a_v_reg;
    assign link_ctl[0].a     = a_rd_reg;
    assign link_k[0]         = a_k_reg;

    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        dmm_cell #(
            .MAX_DIM (MAX_DIM),
            .IDX_W   (IDX_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (start),
            .wr_en   (b_wr && (32'(in_col) == j)),
            .wr_row  (IDX_W'(in_row)),
            .wr_data (in_val),
            .in_ctl  (link_ctl[j]),
            .in_k    (link_k[j]),
            .out_ctl (link_ctl[j+1]),
            .out_k   (link_k[j+1]),
            .acc     (acc[j])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Emitted column stays inside the active size
    `ASSERT_IMPL(a_col_in_range, m_tvalid, 32'(m_tdata[3:0]) < 32'(n_eff),
        "emitted column beyond active size")
    // The last word of a row carries column n-1
    `ASSERT_IMPL(a_last_col, m_tvalid && m_tlast, 32'(m_tdata[3:0]) + 1 == 32'(n_eff),
        "tlast on wrong column")
    // A started row leaves idle on the next edge
    `ASSERT_CLK(a_start_run, start |=> state_reg == ST_RUN, "compute did not start")
    // No emission while the chain is still streaming
    `ASSERT_IMPL(a_no_emit_in_run, state_reg == ST_RUN, !emit_now,
        "emission during streaming")

endmodule
